// ===== rtl/pic_pkg.sv =====
package pic_pkg;

  // Bus access kinds and line events carried by one input transaction.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_NONE  = 2'd3
  } pic_opcode_t;

  // Register window offsets.
  localparam logic [21:0] OFF_PENDING = 22'h001000;
  localparam logic [21:0] OFF_ENABLE  = 22'h002000;
  localparam logic [21:0] OFF_CONTEXT = 22'h200000;
  localparam logic [21:0] OFF_CLAIM   = 22'h200004;

  typedef struct packed {
    pic_opcode_t opcode;
    logic [21:0] reg_offset;
    logic [31:0] write_data;
    logic [4:0]  irq_source;
    logic        irq_level;
  } pic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt_pending;
  } pic_out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_DONE
  } pic_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic out_load;
  } pic_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic done;
  } pic_status_t;

endpackage

// ===== rtl/pic_arb.sv =====
module pic_arb import pic_pkg::*; #(
  parameter int NUM_SOURCES = 31,
  localparam int IDX_W  = $clog2(NUM_SOURCES + 1),
  localparam int LEAVES = 1 << IDX_W,
  localparam int NODES  = 2 * LEAVES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LEAVES-1:0] elig,
  input  logic [31:0]       prio [LEAVES],
  input  logic [31:0]       thr,
  output logic              best_valid,
  output logic [IDX_W-1:0]  best_id,
  output logic              done
);

  // Heap-ordered registered tree: leaves at LEAVES + n, root at node 1.
  logic             node_v  [1:NODES-1];
  logic [31:0]      node_p  [1:NODES-1];
  logic [IDX_W-1:0] node_id [1:NODES-1];

  logic             leaf_v  [LEAVES];
  logic             take_r  [1:LEAVES-1];
  logic [IDX_W+1:0] tok;

  // A source competes when it is a real source, eligible, and beats the threshold.
  always_comb begin
    for (int n = 0; n < LEAVES; n++) begin
      leaf_v[n] = (n >= 1) && (n <= NUM_SOURCES) && elig[n] && (prio[n] > thr);
    end
  end

  // The right child wins only on a strictly higher priority, so ties keep the lower id.
  always_comb begin
    for (int i = 1; i < LEAVES; i++) begin
      take_r[i] = node_v[2*i+1] && (!node_v[2*i] || (node_p[2*i+1] > node_p[2*i]));
    end
  end

  // Tree registers: every level is recomputed each cycle from the level below.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i < NODES; i++) begin
        node_v[i] <= 1'b0;
      end
    end else begin
      for (int n = 0; n < LEAVES; n++) begin
        node_v[LEAVES+n] <= leaf_v[n];
      end
      for (int i = 1; i < LEAVES; i++) begin
        node_v[i] <= take_r[i] ? node_v[2*i+1] : node_v[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < LEAVES; n++) begin
      node_p[LEAVES+n]  <= prio[n];
      node_id[LEAVES+n] <= IDX_W'(n);
    end
    for (int i = 1; i < LEAVES; i++) begin
      node_p[i]  <= take_r[i] ? node_p[2*i+1]  : node_p[2*i];
      node_id[i] <= take_r[i] ? node_id[2*i+1] : node_id[2*i];
    end
  end

  // A token follows a state change through the leaf stage and every tree level.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= {tok[IDX_W:0], start};
    end
  end

  assign best_valid = node_v[1];
  assign best_id    = node_id[1];
  assign done       = tok[IDX_W+1];

endmodule

// ===== rtl/pic_dp.sv =====
module pic_dp import pic_pkg::*; #(
  parameter int NUM_SOURCES = 31,
  localparam int IDX_W  = $clog2(NUM_SOURCES + 1),
  localparam int LEAVES = 1 << IDX_W
) (
  input  logic        clk,
  input  logic        rst,
  input  pic_cmd_t    cmd,
  input  pic_in_t     in_data,
  output pic_status_t status,
  output pic_out_t    out_data
);

  pic_in_t           item;
  logic [31:0]       prio [LEAVES];
  logic [31:0]       en;
  logic [31:0]       pend;
  logic [LEAVES-1:0] clm;
  logic [31:0]       thr;
  logic [31:0]       rd_hold;
  logic [31:0]       rd_next;

  logic              best_valid;
  logic [IDX_W-1:0]  best_id;
  logic              arb_done;

  logic [9:0]        slot;
  logic              hit_prio;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  cpl_idx;
  logic              cpl_ok;

  // Hold the accepted transaction for the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // Address decode of the held bus access.
  assign slot     = item.reg_offset[11:2];
  assign hit_prio = (item.reg_offset[21:12] == '0) && (slot <= 10'(NUM_SOURCES));
  assign slot_idx = slot[IDX_W-1:0];
  assign cpl_idx  = item.write_data[IDX_W-1:0];
  assign cpl_ok   = (item.write_data != '0) && (item.write_data <= 32'(NUM_SOURCES)) &&
                    clm[cpl_idx];

  // Read data, including the claim result taken from the current winner.
  always_comb begin
    rd_next = '0;
    if (item.opcode == OP_READ) begin
      if (hit_prio) begin
        rd_next = prio[slot_idx];
      end else if (item.reg_offset == OFF_PENDING) begin
        rd_next = pend;
      end else if (item.reg_offset == OFF_ENABLE) begin
        rd_next = en;
      end else if (item.reg_offset == OFF_CONTEXT) begin
        rd_next = thr;
      end else if (item.reg_offset == OFF_CLAIM) begin
        rd_next = best_valid ? 32'(best_id) : '0;
      end
    end
  end

  // Controller state update in the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEAVES; i++) begin
        prio[i] <= '0;
      end
      en   <= '0;
      pend <= '0;
      clm  <= '0;
      thr  <= '0;
    end else if (cmd.exec) begin
      unique case (item.opcode)
        OP_READ: begin
          if ((item.reg_offset == OFF_CLAIM) && best_valid) begin
            pend[best_id] <= 1'b0;
            clm[best_id]  <= 1'b1;
          end
        end
        OP_WRITE: begin
          if (hit_prio) begin
            prio[slot_idx] <= item.write_data;
          end else if (item.reg_offset == OFF_ENABLE) begin
            en <= item.write_data;
          end else if (item.reg_offset == OFF_CONTEXT) begin
            thr <= item.write_data;
          end else if ((item.reg_offset == OFF_CLAIM) && cpl_ok) begin
            clm[cpl_idx] <= 1'b0;
          end
        end
        OP_LINE: begin
          pend[item.irq_source] <= item.irq_level;
        end
        default: begin
        end
      endcase
    end
  end

  // Read data waits here while the winner is recomputed.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_hold <= rd_next;
    end
  end

  // Output register: the interrupt line reflects the state after the transaction.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.read_data         <= rd_hold;
      out_data.interrupt_pending <= best_valid;
    end
  end

  pic_arb #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_arb (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec),
    .elig      (pend[LEAVES-1:0] & en[LEAVES-1:0] & ~clm),
    .prio      (prio),
    .thr       (thr),
    .best_valid(best_valid),
    .best_id   (best_id),
    .done      (arb_done)
  );

  assign status.done = arb_done;

endmodule

// ===== rtl/pic_ctrl.sv =====
module pic_ctrl import pic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  pic_status_t status,
  output pic_cmd_t    cmd
);

  pic_state_t state;
  pic_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_WAIT: begin
      end
      ST_DONE: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // The output register is full from its load until the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EXEC && cmd.exec))
    else $error("accepted transaction did not enter execute");

  a_done_unload: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && status.done) |=> (state == ST_DONE))
    else $error("winner ready but sequencer did not move to unload");

  a_load_full: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && state == ST_IDLE))
    else $error("result load did not fill the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

// ===== rtl/platform_interrupt_controller_unit.sv =====
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-------------------------------
// in      | input     | in_valid / in_ready  | in_data  (pic_in_t)
// out     | output    | out_valid / out_ready| out_data (pic_out_t)
//
// One transaction is worked at a time; a new one is taken only after the previous
// result has been loaded into the output register.
// The wait is set by the registered winner tree: a leaf stage plus one level per id bit.
// Reset is synchronous and clears all masks, priorities, the threshold and the sequencer.
// A result waiting on out_ready does not block acceptance of the next transaction;
// only the unload of the following result stalls until the output register is free.
module platform_interrupt_controller_unit import pic_pkg::*; #(
  parameter int NUM_SOURCES = 31
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pic_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pic_out_t out_data
);

  pic_cmd_t    cmd;
  pic_status_t status;

  pic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pic_dp #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .status  (status),
    .out_data(out_data)
  );

endmodule
